/* src/gcd_pkg.sv */
// ----------------------------------------------------------------------------
// Great-circle distance package
// Shared types, constants and elaboration-time helpers for the
// haversine distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int MAX_STAGES = 40;
    localparam int CW         = 34;   // CORDIC datapath width
    localparam int RW         = 31;   // square root result width
    localparam int HW         = 61;   // haversine term width (Q60, up to 1.0)

    typedef logic signed [CW-1:0] cord_t;
    typedef logic signed [31:0]   trig_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURNS [MAX_STAGES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1,
        32'd1, 32'd0, 32'd0, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

    localparam logic signed [33:0] FULL_TURN = 34'sd3600000000;
    localparam logic signed [33:0] TWO_TURNS = 34'sd7200000000;
    localparam logic [31:0]        PHASE_MUL = 32'd2562047788;
    localparam logic [33:0]        DIST_MUL  = 34'd10247738594;
    localparam logic [HW-1:0]      Q60_ONE   = {1'b1, 60'd0};

    // Reduce an angle difference into one full turn.
    // A longitude difference can reach just past minus one turn, so the
    // most negative values need two turns added.
    function automatic logic [31:0] wrap_turn(input logic signed [33:0] d);
        logic signed [33:0] m;
        m = d;
        if (d < -FULL_TURN) begin
            m = d + TWO_TURNS;
        end else if (d < 0) begin
            m = d + FULL_TURN;
        end else if (d >= FULL_TURN) begin
            m = d - FULL_TURN;
        end
        return m[31:0];
    endfunction

    // Limit the stage count to the table length.
    function automatic int stage_clamp(input int n);
        if (n > MAX_STAGES) return MAX_STAGES;
        if (n < 1) return 1;
        return n;
    endfunction

    // Squared CORDIC gain in Q62, truncated at each step.
    function automatic logic [63:0] gain_sq(input int n);
        logic [63:0] g;
        g = 64'd1 << 62;
        for (int i = 0; i < MAX_STAGES; i++) begin
            if (i < n) begin
                if (i == 0) g = g << 1;
                else g = g + (g >> (2 * i));
            end
        end
        return g;
    endfunction

    // Floor square root, used only for elaboration constants.
    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > v) b = b >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

endpackage

/* src/gcd_sincos.sv */
// ----------------------------------------------------------------------------
// Rotation-mode CORDIC
// Pipelined sine and cosine of a 32-bit binary phase, one stage per
// micro-rotation, with quadrant folding at the input and output.
// ----------------------------------------------------------------------------
module gcd_sincos #(
    parameter int STAGES = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [31:0]   phase,
    output logic          out_valid,
    output gcd_pkg::trig_t cos_out,
    output gcd_pkg::trig_t sin_out
);
    import gcd_pkg::*;

    localparam int          N     = stage_clamp(STAGES);
    localparam logic [63:0] GSQ   = gain_sq(N);
    localparam logic [63:0] ROOT  = isqrt64(GSQ);
    localparam logic [63:0] SEED  = ((64'd1 << 61) + (ROOT >> 1)) / ROOT;

    cord_t       x_reg [N+1];
    cord_t       y_reg [N+1];
    cord_t       z_reg [N+1];
    logic [1:0]  q_reg [N+1];
    logic        v_reg [N+1];

    logic [31:0] ph_rnd;
    logic [1:0]  q_in;
    logic [31:0] resid;

    // Nearest quadrant and the residual angle within it.
    assign ph_rnd = phase + 32'h2000_0000;
    assign q_in   = ph_rnd[31:30];
    assign resid  = phase - {q_in, 30'd0};

    // Input stage: seed vector and residual angle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= cord_t'(SEED[CW-1:0]);
            y_reg[0] <= '0;
            z_reg[0] <= cord_t'($signed(resid));
            q_reg[0] <= q_in;
        end
    end

    // Micro-rotation stages.
    for (genvar i = 0; i < N; i++) begin : g_stage
        cord_t dx;
        cord_t dy;
        cord_t at;

        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;
        assign at = cord_t'({2'b00, ATAN_TURNS[i]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - at;
                end else begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    cord_t cos_next;
    cord_t sin_next;
    trig_t cos_reg;
    trig_t sin_reg;
    logic  valid_reg;

    // Rotate the result back into its quadrant.
    always_comb begin
        case (q_reg[N])
            2'd0: begin
                cos_next = x_reg[N];
                sin_next = y_reg[N];
            end
            2'd1: begin
                cos_next = -y_reg[N];
                sin_next = x_reg[N];
            end
            2'd2: begin
                cos_next = -x_reg[N];
                sin_next = -y_reg[N];
            end
            default: begin
                cos_next = y_reg[N];
                sin_next = -x_reg[N];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= v_reg[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= trig_t'(cos_next[31:0]);
            sin_reg <= trig_t'(sin_next[31:0]);
        end
    end

    assign out_valid = valid_reg;
    assign cos_out   = cos_reg;
    assign sin_out   = sin_reg;

endmodule

/* src/gcd_isqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined square root
// Floor square root of a Q60 value, one result bit per register stage.
// ----------------------------------------------------------------------------
module gcd_isqrt (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [gcd_pkg::HW-1:0] value,
    output logic                 out_valid,
    output logic [gcd_pkg::RW-1:0] root
);
    import gcd_pkg::*;

    logic [HW-1:0] rem_reg [RW];
    logic [RW-1:0] r_reg   [RW];
    logic          v_reg   [RW];

    // Each stage decides one bit, most significant first.
    for (genvar g = 0; g < RW; g++) begin : g_bit
        localparam int J = RW - 1 - g;

        logic [HW-1:0] cur_rem;
        logic [RW-1:0] cur_r;
        logic          cur_v;
        logic [63:0]   trial;
        logic [63:0]   diff;
        logic          fits;

        if (g == 0) begin : g_first
            assign cur_rem = value;
            assign cur_r   = '0;
            assign cur_v   = in_valid;
        end else begin : g_rest
            assign cur_rem = rem_reg[g-1];
            assign cur_r   = r_reg[g-1];
            assign cur_v   = v_reg[g-1];
        end

        // (r + 2^J)^2 - r^2 = r * 2^(J+1) + 2^(2J)
        assign trial = ({{(64-RW){1'b0}}, cur_r} << (J + 1)) + (64'd1 << (2 * J));
        assign fits  = {{(64-HW){1'b0}}, cur_rem} >= trial;
        assign diff  = {{(64-HW){1'b0}}, cur_rem} - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= cur_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (fits) begin
                    rem_reg[g] <= diff[HW-1:0];
                    r_reg[g]   <= cur_r | (RW'(1) << J);
                end else begin
                    rem_reg[g] <= cur_rem;
                    r_reg[g]   <= cur_r;
                end
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root      = r_reg[RW-1];

endmodule

/* src/gcd_vecangle.sv */
// ----------------------------------------------------------------------------
// Vectoring-mode CORDIC
// Pipelined angle of the vector (x, y) in 2^-32 turn, clamped to a
// quarter turn.
// ----------------------------------------------------------------------------
module gcd_vecangle #(
    parameter int STAGES = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [gcd_pkg::RW-1:0] x_in,
    input  logic [gcd_pkg::RW-1:0] y_in,
    output logic                 out_valid,
    output logic [30:0]          theta
);
    import gcd_pkg::*;

    localparam int N = stage_clamp(STAGES);

    cord_t x_reg [N];
    cord_t y_reg [N];
    cord_t z_reg [N];
    logic  v_reg [N];

    // Micro-rotation stages driving y toward zero.
    for (genvar i = 0; i < N; i++) begin : g_stage
        cord_t cur_x;
        cord_t cur_y;
        cord_t cur_z;
        logic  cur_v;
        cord_t dx;
        cord_t dy;
        cord_t at;

        if (i == 0) begin : g_first
            assign cur_x = cord_t'({{(CW-RW){1'b0}}, x_in});
            assign cur_y = cord_t'({{(CW-RW){1'b0}}, y_in});
            assign cur_z = '0;
            assign cur_v = in_valid;
        end else begin : g_rest
            assign cur_x = x_reg[i-1];
            assign cur_y = y_reg[i-1];
            assign cur_z = z_reg[i-1];
            assign cur_v = v_reg[i-1];
        end

        assign dx = cur_y >>> i;
        assign dy = cur_x >>> i;
        assign at = cord_t'({2'b00, ATAN_TURNS[i]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= cur_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (cur_y >= 0) begin
                    x_reg[i] <= cur_x + dx;
                    y_reg[i] <= cur_y - dy;
                    z_reg[i] <= cur_z + at;
                end else begin
                    x_reg[i] <= cur_x - dx;
                    y_reg[i] <= cur_y + dy;
                    z_reg[i] <= cur_z - at;
                end
            end
        end
    end

    logic        valid_reg;
    logic [30:0] theta_reg;
    logic [30:0] theta_next;

    // Clamp the accumulated angle to [0, 1/4 turn].
    always_comb begin
        if (z_reg[N-1] < 0) begin
            theta_next = '0;
        end else if (z_reg[N-1] > cord_t'(34'sd1073741824)) begin
            theta_next = 31'h4000_0000;
        end else begin
            theta_next = z_reg[N-1][30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= v_reg[N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            theta_reg <= theta_next;
        end
    end

    assign out_valid = valid_reg;
    assign theta     = theta_reg;

endmodule

/* src/great_circle_distance_top.sv */
// Throughput: one point pair per cycle unless stalled; every unit is fully pipelined.
// The sine/cosine CORDIC, the 31-stage square root and the angle CORDIC set the depth.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset: aresetn is synchronous, active low, and clears all valid bits.
// ----------------------------------------------------------------------------
// Great-circle distance top level
// Haversine distance between two latitude/longitude points, in 1/256 metre.
// ----------------------------------------------------------------------------
module great_circle_distance_top #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [30:0] first_latitude, [62:31] first_longitude,
    // [93:63] second_latitude, [125:94] second_longitude, [127:126] zero
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [32:0] distance, [39:33] zero
    output logic [39:0]  m_tdata
);
    import gcd_pkg::*;

    localparam logic [16:0] DIST_LO = DIST_MUL[16:0];
    localparam logic [16:0] DIST_HI = DIST_MUL[33:17];

    logic en;
    logic out_valid_reg;

    // The pipeline advances unless a held result is not being taken.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Input fields.
    logic signed [30:0] lat1;
    logic signed [31:0] lon1;
    logic signed [30:0] lat2;
    logic signed [31:0] lon2;

    assign lat1 = $signed(s_tdata[30:0]);
    assign lon1 = $signed(s_tdata[62:31]);
    assign lat2 = $signed(s_tdata[93:63]);
    assign lon2 = $signed(s_tdata[125:94]);

    // Stage 1: differences and latitudes reduced into one turn.
    logic        v1_reg;
    logic [31:0] dlat_reg;
    logic [31:0] dlon_reg;
    logic [31:0] wl1_reg;
    logic [31:0] wl2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dlat_reg <= wrap_turn(34'(lat2) - 34'(lat1));
            dlon_reg <= wrap_turn(34'(lon2) - 34'(lon1));
            wl1_reg  <= wrap_turn(34'(lat1));
            wl2_reg  <= wrap_turn(34'(lat2));
        end
    end

    // Stage 2: scale to binary phase.
    logic        v2_reg;
    logic [63:0] pdlat_reg;
    logic [63:0] pdlon_reg;
    logic [63:0] pl1_reg;
    logic [63:0] pl2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pdlat_reg <= 64'(dlat_reg) * 64'(PHASE_MUL);
            pdlon_reg <= 64'(dlon_reg) * 64'(PHASE_MUL);
            pl1_reg   <= 64'(wl1_reg) * 64'(PHASE_MUL);
            pl2_reg   <= 64'(wl2_reg) * 64'(PHASE_MUL);
        end
    end

    // Rounded phases: half angles for the differences, full for latitudes.
    logic [63:0] rdlat;
    logic [63:0] rdlon;
    logic [63:0] rl1;
    logic [63:0] rl2;

    assign rdlat = pdlat_reg + (64'd1 << 31);
    assign rdlon = pdlon_reg + (64'd1 << 31);
    assign rl1   = pl1_reg + (64'd1 << 30);
    assign rl2   = pl2_reg + (64'd1 << 30);

    // Four sine/cosine units in parallel.
    logic  sv_dlat, sv_dlon, sv_l1, sv_l2;
    trig_t s1, s2, c1, c2;

    gcd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlat (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v2_reg),
        .phase(rdlat[63:32]), .out_valid(sv_dlat), .cos_out(), .sin_out(s1)
    );

    gcd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlon (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v2_reg),
        .phase(rdlon[63:32]), .out_valid(sv_dlon), .cos_out(), .sin_out(s2)
    );

    gcd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v2_reg),
        .phase(rl1[62:31]), .out_valid(sv_l1), .cos_out(c1), .sin_out()
    );

    gcd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v2_reg),
        .phase(rl2[62:31]), .out_valid(sv_l2), .cos_out(c2), .sin_out()
    );

    // Haversine stage 1: first products.
    logic               vp1_reg;
    logic signed [63:0] c1c2_reg;
    logic signed [63:0] s1sq1_reg;
    logic signed [63:0] s2s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp1_reg <= 1'b0;
        end else if (en) begin
            vp1_reg <= sv_dlat && sv_dlon && sv_l1 && sv_l2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1c2_reg  <= 64'(c1) * 64'(c2);
            s1sq1_reg <= 64'(s1) * 64'(s1);
            s2s2_reg  <= 64'(s2) * 64'(s2);
        end
    end

    // Haversine stage 2: round the Q60 products back to Q30.
    logic               vp2_reg;
    logic signed [33:0] cc_reg;
    logic signed [33:0] s2sq_reg;
    logic signed [63:0] s1sq2_reg;
    logic signed [63:0] cc_rnd;
    logic signed [63:0] s2_rnd;

    assign cc_rnd = c1c2_reg + 64'sd536870912;
    assign s2_rnd = s2s2_reg + 64'sd536870912;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp2_reg <= 1'b0;
        end else if (en) begin
            vp2_reg <= vp1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cc_reg    <= $signed(cc_rnd[63:30]);
            s2sq_reg  <= $signed(s2_rnd[63:30]);
            s1sq2_reg <= s1sq1_reg;
        end
    end

    // Haversine stage 3: cos*cos*sin^2 product.
    logic               vp3_reg;
    logic signed [67:0] prod_reg;
    logic signed [63:0] s1sq3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp3_reg <= 1'b0;
        end else if (en) begin
            vp3_reg <= vp2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= 68'(cc_reg) * 68'(s2sq_reg);
            s1sq3_reg <= s1sq2_reg;
        end
    end

    // Haversine stage 4: sum and clamp to [0, 1].
    logic               vp4_reg;
    logic [HW-1:0]      h_reg;
    logic [HW-1:0]      h_next;
    logic signed [68:0] hsum;

    assign hsum = 69'(s1sq3_reg) + 69'(prod_reg);

    always_comb begin
        if (hsum < 0) begin
            h_next = '0;
        end else if (hsum > 69'sd1152921504606846976) begin
            h_next = Q60_ONE;
        end else begin
            h_next = hsum[HW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp4_reg <= 1'b0;
        end else if (en) begin
            vp4_reg <= vp3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg <= h_next;
        end
    end

    // Square roots of h and 1 - h.
    logic          sq_v_ok, sq_w_ok;
    logic [RW-1:0] root_h;
    logic [RW-1:0] root_c;
    logic [HW-1:0] h_comp;

    assign h_comp = Q60_ONE - h_reg;

    gcd_isqrt u_sqrt_h (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vp4_reg),
        .value(h_reg), .out_valid(sq_v_ok), .root(root_h)
    );

    gcd_isqrt u_sqrt_c (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vp4_reg),
        .value(h_comp), .out_valid(sq_w_ok), .root(root_c)
    );

    // Half the central angle as atan2(sqrt(h), sqrt(1 - h)).
    logic        va_ok;
    logic [30:0] theta;

    gcd_vecangle #(.STAGES(CORDIC_STAGES)) u_angle (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(sq_v_ok && sq_w_ok),
        .x_in(root_c), .y_in(root_h), .out_valid(va_ok), .theta(theta)
    );

    // Scale stage 1: split the 34-bit constant into two partial products.
    logic        vm1_reg;
    logic [47:0] plo_reg;
    logic [47:0] phi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm1_reg <= 1'b0;
        end else if (en) begin
            vm1_reg <= va_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg <= 48'(theta) * 48'(DIST_LO);
            phi_reg <= 48'(theta) * 48'(DIST_HI);
        end
    end

    // Scale stage 2: combine, round and hold the result for transfer.
    logic [65:0] total;
    logic [32:0] dist_reg;

    assign total = (66'(phi_reg) << 17) + 66'(plo_reg) + (66'd1 << 30);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vm1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= total[63:31];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, dist_reg};

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Great-circle distance testbench
// Drives point pairs into the haversine pipeline under several stall
// patterns, predicts each distance with a bit-exact fixed-point model and
// checks results in order.
// ----------------------------------------------------------------------------
module testbench;

    import gcd_pkg::*;

    localparam int          STAGES     = 24;
    localparam int          CYCLE_CAP  = 400000;
    localparam int          DRAIN_WAIT = 2 * STAGES + 80;
    localparam longint      TURN_UNITS = 64'sd3600000000;
    localparam longint      LAT_MAX    = 64'sd900000000;
    localparam longint      LON_MAX    = 64'sd1800000000;
    localparam longint      ONE_Q60    = 64'sd1 << 60;
    localparam longint      ONE_Q30    = 64'sd1 << 30;
    localparam longint unsigned K_PHASE = 64'd2562047788;
    localparam longint unsigned K_DIST  = 64'd10247738594;

    // Distance predictor and in-order store of expected distances.
    class distance_board;
        longint unsigned dist_q[$];
        int              errors;
        int              n_stages;
        longint          seed;
        longint          atan_tab[MAX_STAGES];

        function new(int stages);
            longint unsigned g;
            longint unsigned r;
            errors   = 0;
            n_stages = (stages > MAX_STAGES) ? MAX_STAGES : (stages < 1 ? 1 : stages);
            for (int i = 0; i < MAX_STAGES; i++) begin
                atan_tab[i] = longint'(ATAN_TURNS[i]);
            end
            // CORDIC start value from the squared gain.
            g = 64'd1 << 62;
            for (int i = 0; i < n_stages; i++) begin
                if (i == 0) g = g << 1;
                else g = g + (g >> (2 * i));
            end
            r = floor_sqrt(g);
            seed = longint'(((64'd1 << 61) + r / 2) / r);
        endfunction

        function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint unsigned reduce_turn(longint d);
            longint m;
            m = d % TURN_UNITS;
            if (m < 0) m = m + TURN_UNITS;
            return longint'(m);
        endfunction

        // Rotation CORDIC after folding the phase to the nearest quadrant.
        function void rotate(logic [31:0] p, output longint c, output longint s);
            logic [31:0] q;
            logic [31:0] u;
            longint      x;
            longint      y;
            longint      z;
            longint      dx;
            longint      dy;
            q = ((p + 32'h2000_0000) >> 30) & 32'd3;
            u = p - (q << 30);
            z = longint'($signed(u));
            x = seed;
            y = 0;
            for (int i = 0; i < n_stages; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - atan_tab[i];
                end else begin
                    x = x + dx; y = y - dy; z = z + atan_tab[i];
                end
            end
            case (q)
                32'd0: begin c = x;  s = y;  end
                32'd1: begin c = -y; s = x;  end
                32'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        // Vectoring CORDIC: angle of (x, y) in 2^-32 turn.
        function longint angle_of(longint x, longint y);
            longint z;
            longint dx;
            longint dy;
            z = 0;
            for (int i = 0; i < n_stages; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx; y = y - dy; z = z + atan_tab[i];
                end else begin
                    x = x - dx; y = y + dy; z = z - atan_tab[i];
                end
            end
            return z;
        endfunction

        function longint unsigned distance_of(logic [127:0] d);
            longint lat1, lon1, lat2, lon2;
            longint c1, c2, s1, s2, dummy, cc, s2sq, h, theta;
            longint unsigned v, w, prod;
            logic [31:0] ph;
            lat1 = longint'($signed(d[30:0]));
            lon1 = longint'($signed(d[62:31]));
            lat2 = longint'($signed(d[93:63]));
            lon2 = longint'($signed(d[125:94]));
            // Half-angle phases of the differences, full phases of the latitudes.
            prod = reduce_turn(lat2 - lat1) * K_PHASE + (64'd1 << 31);
            ph = prod[63:32];
            rotate(ph, dummy, s1);
            prod = reduce_turn(lon2 - lon1) * K_PHASE + (64'd1 << 31);
            ph = prod[63:32];
            rotate(ph, dummy, s2);
            prod = reduce_turn(lat1) * K_PHASE + (64'd1 << 30);
            ph = prod[62:31];
            rotate(ph, c1, dummy);
            prod = reduce_turn(lat2) * K_PHASE + (64'd1 << 30);
            ph = prod[62:31];
            rotate(ph, c2, dummy);
            cc   = (c1 * c2 + (64'sd1 << 29)) >>> 30;
            s2sq = (s2 * s2 + (64'sd1 << 29)) >>> 30;
            h = s1 * s1 + cc * s2sq;
            if (h < 0) h = 0;
            if (h > ONE_Q60) h = ONE_Q60;
            v = floor_sqrt(longint'(h));
            w = floor_sqrt(longint'(ONE_Q60 - h));
            theta = angle_of(longint'(w), longint'(v));
            if (theta < 0) theta = 0;
            if (theta > ONE_Q30) theta = ONE_Q30;
            prod = (longint'(theta) * K_DIST + (64'd1 << 30)) >> 31;
            return prod & 64'h1_FFFF_FFFF;
        endfunction

        function void note_pair(logic [127:0] d);
            dist_q.insert(dist_q.size(), distance_of(d));
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_distance(logic [39:0] r);
            longint unsigned want;
            if (dist_q.size() == 0) begin
                report($sformatf("unexpected result %0d", r[32:0]));
            end else begin
                want = dist_q.pop_front();
                if (longint'(r[32:0]) != want)
                    report($sformatf("distance got %0d want %0d", r[32:0], want));
            end
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;

    distance_board board;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            cycles;

    great_circle_distance_top #(.CORDIC_STAGES(STAGES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Clock with period 4.
    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    initial begin
        board          = new(STAGES);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycles         = 0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
    end

    // Cycle limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watch both channels for transfers.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_pair(s_tdata);
        if (aresetn && m_tvalid && m_tready) board.check_distance(m_tdata);
    end

    function logic [127:0] pack_pair(logic [30:0] la1, logic [31:0] lo1,
                                     logic [30:0] la2, logic [31:0] lo2);
        return {2'b00, lo2, la2, lo1, la1};
    endfunction

    // One input transfer, with optional idle cycles before it.
    task send_pair(logic [127:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task send_deg(longint la1, longint lo1, longint la2, longint lo2);
        send_pair(pack_pair(la1[30:0], lo1[31:0], la2[30:0], lo2[31:0]));
    endtask

    function longint rand_lat();
        return longint'($urandom_range(1800000000)) - LAT_MAX;
    endfunction

    function longint rand_lon();
        return longint'($urandom_range(32'd3600000000)) - LON_MAX;
    endfunction

    task send_random();
        int     kind;
        longint la, lo;
        kind = $urandom_range(99);
        la = rand_lat();
        lo = rand_lon();
        if (kind < 60) begin
            send_deg(la, lo, rand_lat(), rand_lon());
        end else if (kind < 72) begin
            // Nearby points.
            send_deg(la, lo, la + $urandom_range(2000) - 1000,
                     lo + $urandom_range(2000) - 1000);
        end else if (kind < 84) begin
            // Near-antipodal points.
            send_deg(la, lo, -la + $urandom_range(20) - 10,
                     (lo > 0 ? lo - LON_MAX : lo + LON_MAX) + $urandom_range(20) - 10);
        end else begin
            // Raw bit patterns, out of range included.
            send_pair({$urandom(), $urandom(), $urandom(), $urandom()}
                      & {2'b00, {126{1'b1}}});
        end
    endtask

    task wait_drained();
        while (board.dist_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corner cases.
        send_deg(0, 0, 0, 0);
        send_deg(LAT_MAX, 0, -LAT_MAX, 0);
        send_deg(0, 0, 0, LON_MAX);
        send_deg(0, -LON_MAX, 0, LON_MAX);
        send_deg(0, LON_MAX, 0, -LON_MAX + 1);
        send_deg(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_deg(-LAT_MAX, 0, -LAT_MAX, 900000000);
        send_deg(453000000, 123456789, -453000000, 123456789 - LON_MAX);
        send_deg(1, 0, 0, 1);
        send_deg(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
        send_pair(pack_pair(31'h3FFF_FFFF, 32'h7FFF_FFFF, 31'h4000_0000, 32'h8000_0000));
        send_pair(pack_pair(31'h4000_0000, 32'h8000_0000, 31'h3FFF_FFFF, 32'h7FFF_FFFF));
        send_pair(pack_pair(31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h0, 32'h0));
        send_deg(1200000000, 0, -1200000000, 0);
        send_deg(515000000, -1000000, 407000000, -740000000);
        send_deg(0, 0, 0, 900000000);
        s_tvalid <= 1'b0;
        // Hold off until the pipeline has emptied.
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            for (int n = 0; n < 235; n++) send_random();
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (board.errors == 0 && board.dist_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
